FILE: src/hash_like_window_redactor_top_assert.svh
// Assertion macros for the hash-like window redactor checker.
// Included by the checker file; depends on clk and rst_n in the including scope.
`ifndef HASH_LIKE_WINDOW_REDACTOR_TOP_ASSERT_SVH
`define HASH_LIKE_WINDOW_REDACTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HLWR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HLWR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/hlwr_pkg.sv
// Shared types and constants for the hash-like window redactor.
// No dependencies; used by the interfaces, all modules and the checker.
package hlwr_pkg;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned BYTES_W     = 4;
    localparam int unsigned THRESH_W    = 5;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic [BYTES_W-1:0]  WORD_BYTES = 4'd8;
    localparam logic [7:0]          HIGH_BYTE_MIN = 8'h80;

    localparam logic [THRESH_W-1:0] MIN_NONZERO_RST    = 5'd8;
    localparam logic [THRESH_W-1:0] MIN_HIGH_BYTES_RST = 5'd5;
    localparam logic [THRESH_W-1:0] MAX_EQUAL_RUN_RST  = 5'd4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CANARY_LOW     = 3'd0,
        CFG_CANARY_HIGH    = 3'd1,
        CFG_MIN_NONZERO    = 3'd2,
        CFG_MIN_HIGH_BYTES = 3'd3,
        CFG_MAX_EQUAL_RUN  = 3'd4
    } cfg_index_t;

    // One classified input transaction: the held word's result and the new word's
    typedef struct packed {
        logic [WORD_W-1:0]  held_word;
        logic [BYTES_W-1:0] held_bytes;
        logic               held_repl;
        logic               has_held;
        logic [WORD_W-1:0]  new_word;
        logic [BYTES_W-1:0] new_bytes;
        logic               new_repl;
        logic               last;
    } entry_t;

endpackage

FILE: src/hlwr_if.sv
// Stream and configuration interfaces of the hash-like window redactor.
// Depends on hlwr_pkg for field widths.
interface hlwr_in_if;
    logic                               valid;
    logic                               ready;
    logic [hlwr_pkg::WORD_W-1:0]        data_word;
    logic [hlwr_pkg::BYTES_W-1:0]       bytes_valid;
    logic                               last_word;

    modport source (output valid, data_word, bytes_valid, last_word, input ready);
    modport sink   (input valid, data_word, bytes_valid, last_word, output ready);
endinterface

interface hlwr_out_if;
    logic                               valid;
    logic                               ready;
    logic [hlwr_pkg::WORD_W-1:0]        out_word;
    logic [hlwr_pkg::BYTES_W-1:0]       out_bytes_valid;
    logic                               was_replaced;
    logic                               end_of_buffer;

    modport source (output valid, out_word, out_bytes_valid, was_replaced, end_of_buffer,
                    input ready);
    modport sink   (input valid, out_word, out_bytes_valid, was_replaced, end_of_buffer,
                    output ready);
endinterface

interface hlwr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [hlwr_pkg::CFG_INDEX_W-1:0]   index;
    logic [hlwr_pkg::WORD_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/hash_like_window_redactor_top.sv
// Top level of the hash-like window redactor.
// Depends on hlwr_pkg, hlwr_if, hlwr_front, hlwr_fifo and hlwr_back.
//
// Usage:
//   item   : buffer words, 8 bytes each, earliest byte in bits 7:0; last_word
//            marks the final word. One per cycle unless the queue fills.
//   result : the same words one transaction late, or canary halves where a
//            16-byte window (held word + new word) looked like a hash.
//   cfg    : register writes (canary_low/high, thresholds); always ready.
//            Write only while the block is idle.
// Order: result.valid for a held word rises only after the next item
// transaction has been written into the queue and then loaded into the
// output register. A last_word item with a held word yields two result
// transactions; the queue absorbs this, so item keeps one per cycle on
// average if result keeps up.
// The front-end classifies in the accept cycle; the queue of FIFO_DEPTH
// entries plus the output register decouple it from result stalls. When the
// queue fills, item.ready drops until result drains.
// Reset clears the held word, the queue and the output valid flag, and loads
// the threshold defaults (8, 5, 4) and zero canary.
module hash_like_window_redactor_top #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    hlwr_in_if.sink     item,
    hlwr_out_if.source  result,
    hlwr_cfg_if.sink    cfg
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_head_valid;
    hlwr_pkg::entry_t q_push_entry;
    hlwr_pkg::entry_t q_head;

    hlwr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .cfg     (cfg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_push_entry)
    );

    hlwr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    hlwr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .result     (result)
    );

endmodule

FILE: src/hlwr_front.sv
// Front end: config registers, held word, and the 16-byte window classifier.
// Depends on hlwr_pkg and hlwr_if; feeds hlwr_fifo with entry_t records.
module hlwr_front (
    input  logic            clk,
    input  logic            rst_n,
    hlwr_in_if.sink         item,
    hlwr_cfg_if.sink        cfg,
    input  logic            q_full,
    output logic            q_push,
    output hlwr_pkg::entry_t q_entry
);

    logic [hlwr_pkg::WORD_W-1:0]   canary_low_reg;
    logic [hlwr_pkg::WORD_W-1:0]   canary_high_reg;
    logic [hlwr_pkg::THRESH_W-1:0] min_nonzero_reg;
    logic [hlwr_pkg::THRESH_W-1:0] min_high_bytes_reg;
    logic [hlwr_pkg::THRESH_W-1:0] max_equal_run_reg;

    logic [hlwr_pkg::WORD_W-1:0]   held_word_reg, held_word_next;
    logic [hlwr_pkg::BYTES_W-1:0]  held_bytes_reg, held_bytes_next;
    logic                          held_present_reg, held_present_next;
    logic                          held_is_canary_reg, held_is_canary_next;

    logic [hlwr_pkg::BYTES_W-1:0]  bv_clamped;
    logic                          accept;
    logic                          try_window;
    logic                          hit;

    // Window test over held word (bytes 0..7) and new word (bytes 8..15).
    function automatic logic window_ok(
        input logic [hlwr_pkg::WORD_W-1:0]   lo,
        input logic [hlwr_pkg::WORD_W-1:0]   hi,
        input logic [hlwr_pkg::THRESH_W-1:0] min_nz,
        input logic [hlwr_pkg::THRESH_W-1:0] min_hi,
        input logic [hlwr_pkg::THRESH_W-1:0] max_run
    );
        logic [2*hlwr_pkg::WORD_W-1:0] win;
        logic [7:0]                    b;
        logic [7:0]                    b_prev;
        logic [hlwr_pkg::THRESH_W-1:0] nz;
        logic [hlwr_pkg::THRESH_W-1:0] hb;
        logic [15:0]                   eq;
        logic [15:0]                   has_run;
        logic                          all_eq;
        logic                          too_long;
        win = {hi, lo};
        nz = '0;
        hb = '0;
        eq = '0;
        for (int i = 0; i < 16; i++) begin
            b = win[i*8 +: 8];
            nz = nz + hlwr_pkg::THRESH_W'(b != 8'd0);
            hb = hb + hlwr_pkg::THRESH_W'(b >= hlwr_pkg::HIGH_BYTE_MIN);
            if (i > 0) begin
                b_prev = win[(i-1)*8 +: 8];
                eq[i] = (b == b_prev);
            end
        end
        // has_run[L]: L neighboring equal pairs in a row, i.e. a run of L+1 bytes
        has_run = '0;
        for (int len = 1; len < 16; len++) begin
            for (int s = 1; s + len <= 16; s++) begin
                all_eq = 1'b1;
                for (int j = 0; j < len; j++) begin
                    all_eq = all_eq & eq[s+j];
                end
                has_run[len] = has_run[len] | all_eq;
            end
        end
        if (max_run == '0) begin
            too_long = |eq;
        end else if (max_run < 5'd16) begin
            too_long = has_run[max_run[3:0]];
        end else begin
            too_long = 1'b0;
        end
        return (nz >= min_nz) && (hb >= min_hi) && !too_long;
    endfunction

    assign cfg.ready  = 1'b1;
    assign item.ready = !q_full;
    assign accept     = item.valid && !q_full;

    assign bv_clamped = (item.bytes_valid > hlwr_pkg::WORD_BYTES) ? hlwr_pkg::WORD_BYTES
                                                                  : item.bytes_valid;

    assign try_window = held_present_reg && !held_is_canary_reg
                        && (held_bytes_reg == hlwr_pkg::WORD_BYTES)
                        && (bv_clamped == hlwr_pkg::WORD_BYTES);
    assign hit = try_window && window_ok(held_word_reg, item.data_word, min_nonzero_reg,
                                         min_high_bytes_reg, max_equal_run_reg);

    always_comb
    begin
        q_entry.held_word  = hit ? canary_low_reg : held_word_reg;
        q_entry.held_bytes = hit ? hlwr_pkg::WORD_BYTES : held_bytes_reg;
        q_entry.held_repl  = hit || held_is_canary_reg;
        q_entry.has_held   = held_present_reg;
        q_entry.new_word   = hit ? canary_high_reg : item.data_word;
        q_entry.new_bytes  = bv_clamped;
        q_entry.new_repl   = hit;
        q_entry.last       = item.last_word;
    end

    // First word of a buffer yields nothing yet, unless it is also the last word
    assign q_push = accept && (held_present_reg || item.last_word);

    always_comb
    begin
        held_word_next      = held_word_reg;
        held_bytes_next     = held_bytes_reg;
        held_present_next   = held_present_reg;
        held_is_canary_next = held_is_canary_reg;
        if (accept) begin
            if (item.last_word) begin
                held_word_next      = '0;
                held_bytes_next     = '0;
                held_present_next   = 1'b0;
                held_is_canary_next = 1'b0;
            end else begin
                held_word_next      = q_entry.new_word;
                held_bytes_next     = bv_clamped;
                held_present_next   = 1'b1;
                held_is_canary_next = hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_word_reg      <= '0;
            held_bytes_reg     <= '0;
            held_present_reg   <= 1'b0;
            held_is_canary_reg <= 1'b0;
        end else begin
            held_word_reg      <= held_word_next;
            held_bytes_reg     <= held_bytes_next;
            held_present_reg   <= held_present_next;
            held_is_canary_reg <= held_is_canary_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            canary_low_reg     <= '0;
            canary_high_reg    <= '0;
            min_nonzero_reg    <= hlwr_pkg::MIN_NONZERO_RST;
            min_high_bytes_reg <= hlwr_pkg::MIN_HIGH_BYTES_RST;
            max_equal_run_reg  <= hlwr_pkg::MAX_EQUAL_RUN_RST;
        end else if (cfg.valid) begin
            case (cfg.index)
                hlwr_pkg::CFG_CANARY_LOW:     canary_low_reg  <= cfg.data;
                hlwr_pkg::CFG_CANARY_HIGH:    canary_high_reg <= cfg.data;
                hlwr_pkg::CFG_MIN_NONZERO:
                    min_nonzero_reg <= cfg.data[hlwr_pkg::THRESH_W-1:0];
                hlwr_pkg::CFG_MIN_HIGH_BYTES:
                    min_high_bytes_reg <= cfg.data[hlwr_pkg::THRESH_W-1:0];
                hlwr_pkg::CFG_MAX_EQUAL_RUN:
                    max_equal_run_reg <= cfg.data[hlwr_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: src/hlwr_fifo.sv
// Small register queue between the classifier and the output sequencer.
// Depends on hlwr_pkg for entry_t.
module hlwr_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hlwr_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output hlwr_pkg::entry_t head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hlwr_pkg::entry_t    entries [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = entries[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: src/hlwr_back.sv
// Back end: turns queued entries into one or two output words, registered.
// Depends on hlwr_pkg and hlwr_if.
module hlwr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  hlwr_pkg::entry_t head,
    output logic             pop,
    hlwr_out_if.source       result
);

    logic                          out_valid_reg, out_valid_next;
    logic [hlwr_pkg::WORD_W-1:0]   out_word_reg, out_word_next;
    logic [hlwr_pkg::BYTES_W-1:0]  out_bytes_reg, out_bytes_next;
    logic                          out_repl_reg, out_repl_next;
    logic                          out_eob_reg, out_eob_next;
    logic                          second_reg, second_next;   // held word already sent
    logic                          load_ok;

    assign load_ok = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        out_word_next  = out_word_reg;
        out_bytes_next = out_bytes_reg;
        out_repl_next  = out_repl_reg;
        out_eob_next   = out_eob_reg;
        second_next    = second_reg;
        pop            = 1'b0;
        if (head_valid && load_ok) begin
            out_valid_next = 1'b1;
            if (!second_reg && head.has_held) begin
                out_word_next  = head.held_word;
                out_bytes_next = head.held_bytes;
                out_repl_next  = head.held_repl;
                out_eob_next   = 1'b0;
                if (head.last) begin
                    second_next = 1'b1;
                end else begin
                    pop = 1'b1;
                end
            end else begin
                out_word_next  = head.new_word;
                out_bytes_next = head.new_bytes;
                out_repl_next  = head.new_repl;
                out_eob_next   = 1'b1;
                second_next    = 1'b0;
                pop            = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        out_bytes_reg <= out_bytes_next;
        out_repl_reg  <= out_repl_next;
        out_eob_reg   <= out_eob_next;
    end

    assign result.valid           = out_valid_reg;
    assign result.out_word        = out_word_reg;
    assign result.out_bytes_valid = out_bytes_reg;
    assign result.was_replaced    = out_repl_reg;
    assign result.end_of_buffer   = out_eob_reg;

endmodule

FILE: src/hlwr_checker.sv
// Port-level checker for the hash-like window redactor, bound to the top level.
// Depends on hlwr_pkg and hash_like_window_redactor_top_assert.svh.
`include "hash_like_window_redactor_top_assert.svh"

module hlwr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           res_valid,
    input logic                           res_ready,
    input logic [hlwr_pkg::WORD_W-1:0]    res_word,
    input logic [hlwr_pkg::BYTES_W-1:0]   res_bytes,
    input logic                           res_repl,
    input logic                           res_eob,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);

    `HLWR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
        res_valid && $stable(res_word) && $stable(res_bytes) && $stable(res_repl) && $stable(res_eob),
        "result changed while stalled")

    `HLWR_ASSERT_SAME(a_repl_full, res_valid && res_repl,
        res_bytes == hlwr_pkg::WORD_BYTES, "replaced word is not a full word")

    `HLWR_ASSERT_SAME(a_bytes_range, res_valid,
        res_bytes <= hlwr_pkg::WORD_BYTES, "byte count above eight")

    `HLWR_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "config write not taken")

endmodule

bind hash_like_window_redactor_top hlwr_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_word  (result.out_word),
    .res_bytes (result.out_bytes_valid),
    .res_repl  (result.was_replaced),
    .res_eob   (result.end_of_buffer),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);
